### hdl/tlsth_pkg.sv
`default_nettype none

package tlsth_pkg;

    localparam int TEMP_W   = 12;
    localparam int HUM_W    = 10;
    localparam int TIME_W   = 32;
    localparam int CMD_W    = 8;
    localparam int DRIVE_W  = 8;
    localparam int CAUSE_W  = 3;
    localparam int FUNC_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_CMD    = 2'd1,
        FUNC_LINK   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_SWITCH   = 3'd1,
        CAUSE_REMOTE   = 3'd2,
        CAUSE_OVERTEMP = 3'd3,
        CAUSE_OVERHUM  = 3'd4,
        CAUSE_FINISHED = 3'd5
    } cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_LIMIT = 3'd0,
        REG_HUM_LIMIT  = 3'd1,
        REG_L1_DUR     = 3'd2,
        REG_L2_DUR     = 3'd3,
        REG_L3_DUR     = 3'd4,
        REG_L1_TARGET  = 3'd5,
        REG_L2_TARGET  = 3'd6,
        REG_L3_TARGET  = 3'd7
    } cfg_idx_t;

    localparam logic [CMD_W-1:0] CMD_ON  = 8'h4F;  // 'O'
    localparam logic [CMD_W-1:0] CMD_OFF = 8'h46;  // 'F'
    localparam logic [CMD_W-1:0] CMD_L1  = 8'h31;  // '1'
    localparam logic [CMD_W-1:0] CMD_L2  = 8'h32;  // '2'
    localparam logic [CMD_W-1:0] CMD_L3  = 8'h33;  // '3'

    localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3 = 2'd3;

    localparam logic [DRIVE_W-1:0] DRIVE_L1 = 8'd127;
    localparam logic [DRIVE_W-1:0] DRIVE_L2 = 8'd191;
    localparam logic [DRIVE_W-1:0] DRIVE_L3 = 8'd255;

    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST = 12'sd420;
    localparam logic [HUM_W-1:0]         HUM_LIMIT_RST  = 10'd750;
    localparam logic [TIME_W-1:0]        L1_DUR_RST     = 32'd660000;
    localparam logic [TIME_W-1:0]        L2_DUR_RST     = 32'd660000;
    localparam logic [TIME_W-1:0]        L3_DUR_RST     = 32'd480000;
    localparam logic signed [TEMP_W-1:0] L1_TARGET_RST  = 12'sd340;
    localparam logic signed [TEMP_W-1:0] L2_TARGET_RST  = 12'sd360;
    localparam logic signed [TEMP_W-1:0] L3_TARGET_RST  = 12'sd380;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_limit;
        logic [HUM_W-1:0]         humidity_limit;
        logic [TIME_W-1:0]        l1_duration;
        logic [TIME_W-1:0]        l2_duration;
        logic [TIME_W-1:0]        l3_duration;
        logic signed [TEMP_W-1:0] l1_target;
        logic signed [TEMP_W-1:0] l2_target;
        logic signed [TEMP_W-1:0] l3_target;
    } cfg_t;

    typedef struct packed {
        func_t                    func;
        logic [TIME_W-1:0]        now_ms;
        logic                     switch_closed;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic [CMD_W-1:0]         cmd_byte;
        logic                     link_up;
    } item_t;

    typedef struct packed {
        logic                active;
        logic [LEVEL_W-1:0]  level;
        logic [DRIVE_W-1:0]  motor_drive;
        logic                heater_on;
        cause_t              shutdown_cause;
        logic                remote_mode;
        logic [TIME_W-1:0]   remaining_ms;
    } result_t;

    // Level zero never occurs, but it falls into the level three slot.
    function automatic logic [DRIVE_W-1:0] drive_for(input logic [LEVEL_W-1:0] lvl);
        logic [DRIVE_W-1:0] d;
        d = (lvl == LEVEL_1) ? DRIVE_L1 : (lvl == LEVEL_2) ? DRIVE_L2 : DRIVE_L3;
        return d;
    endfunction

endpackage

`default_nettype wire

### hdl/timed_level_sequencer_with_thermostat_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  s_tdata (sample, command, link), s_tuser (func)
// m_       out        m_tvalid/m_tready  m_tdata (one result per request)
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request is registered on acceptance and its result is captured in the output
// register when the input stage advances, so one request is taken every cycle
// while m_tready does not stall the output. The state update and the elapsed-time
// subtract and compare sit between the input register and the output register.
// Reset is synchronous on aresetn low; it clears both stages and the state.
// A stall on m_tready holds the result; the input stage fills, then s_tready drops.
`default_nettype none

module timed_level_sequencer_with_thermostat_unit
    import tlsth_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] now_ms, [32] switch_closed, [44:33] temperature, [54:45] humidity,
    // [62:55] cmd_byte, [63] link_up
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] func
    input  wire logic [FUNC_W-1:0]     s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] active, [2:1] level, [10:3] motor_drive, [11] heater_on,
    // [14:12] shutdown_cause, [15] remote_mode, [47:16] remaining_ms
    output logic [OUT_DATA_W-1:0]      m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;
    logic    s_accept;

    assign cfg_ready = 1'b1;

    tlsth_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.func          <= func_t'(s_tuser);
            item_reg.now_ms        <= s_tdata[31:0];
            item_reg.switch_closed <= s_tdata[32];
            item_reg.temperature   <= s_tdata[44:33];
            item_reg.humidity      <= s_tdata[54:45];
            item_reg.cmd_byte      <= s_tdata[62:55];
            item_reg.link_up       <= s_tdata[63];
        end
    end

    tlsth_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.remaining_ms, out_reg.remote_mode, out_reg.shutdown_cause,
                       out_reg.heater_on, out_reg.motor_drive, out_reg.level,
                       out_reg.active};

endmodule

`default_nettype wire

### hdl/tlsth_cfg.sv
`default_nettype none

module tlsth_cfg
    import tlsth_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (cfg_idx_t'(wr_index))
                REG_TEMP_LIMIT: cfg_next.temp_limit     = wr_data[TEMP_W-1:0];
                REG_HUM_LIMIT:  cfg_next.humidity_limit = wr_data[HUM_W-1:0];
                REG_L1_DUR:     cfg_next.l1_duration    = wr_data[TIME_W-1:0];
                REG_L2_DUR:     cfg_next.l2_duration    = wr_data[TIME_W-1:0];
                REG_L3_DUR:     cfg_next.l3_duration    = wr_data[TIME_W-1:0];
                REG_L1_TARGET:  cfg_next.l1_target      = wr_data[TEMP_W-1:0];
                REG_L2_TARGET:  cfg_next.l2_target      = wr_data[TEMP_W-1:0];
                REG_L3_TARGET:  cfg_next.l3_target      = wr_data[TEMP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_limit     <= TEMP_LIMIT_RST;
            cfg_reg.humidity_limit <= HUM_LIMIT_RST;
            cfg_reg.l1_duration    <= L1_DUR_RST;
            cfg_reg.l2_duration    <= L2_DUR_RST;
            cfg_reg.l3_duration    <= L3_DUR_RST;
            cfg_reg.l1_target      <= L1_TARGET_RST;
            cfg_reg.l2_target      <= L2_TARGET_RST;
            cfg_reg.l3_target      <= L3_TARGET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/tlsth_core.sv
`default_nettype none

module tlsth_core
    import tlsth_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output result_t      result
);

    logic               active_reg,  active_next;
    logic [LEVEL_W-1:0] level_reg,   level_next;
    logic [TIME_W-1:0]  start_reg,   start_next;
    logic               remote_reg,  remote_next;
    logic [DRIVE_W-1:0] drive_reg,   drive_next;
    logic               heater_reg,  heater_next;

    logic [TIME_W-1:0]  elapsed_old;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  dur_cur;
    logic [TIME_W-1:0]  dur_fin;
    logic signed [TEMP_W-1:0] target;
    logic               restarted;
    logic               ended;
    cause_t             cause;

    // Time since the stored level start; where this very item sets the level, zero is used instead.
    assign elapsed_old = item.now_ms - start_reg;

    always_comb begin
        active_next = active_reg;
        level_next  = level_reg;
        start_next  = start_reg;
        remote_next = remote_reg;
        drive_next  = drive_reg;
        heater_next = heater_reg;
        restarted   = 1'b0;
        ended       = 1'b0;
        cause       = CAUSE_NONE;
        elapsed     = '0;
        dur_cur     = '0;
        target      = '0;

        case (item.func)
            FUNC_LINK: begin
                remote_next = item.link_up;
            end
            FUNC_CMD: begin
                case (item.cmd_byte)
                    CMD_ON: begin
                        if (!active_reg) begin
                            active_next = 1'b1;
                            level_next  = LEVEL_1;
                            restarted   = 1'b1;
                        end
                    end
                    CMD_OFF: begin
                        if (active_reg) begin
                            active_next = 1'b0;
                            heater_next = 1'b0;
                            cause       = CAUSE_REMOTE;
                        end
                    end
                    CMD_L1: begin
                        level_next = LEVEL_1;
                        restarted  = 1'b1;
                    end
                    CMD_L2: begin
                        level_next = LEVEL_2;
                        restarted  = 1'b1;
                    end
                    CMD_L3: begin
                        level_next = LEVEL_3;
                        restarted  = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_SAMPLE: begin
                if (!remote_reg) begin
                    if (item.switch_closed) begin
                        if (!active_reg) begin
                            active_next = 1'b1;
                            level_next  = LEVEL_1;
                            restarted   = 1'b1;
                        end
                    end else if (active_reg) begin
                        active_next = 1'b0;
                        heater_next = 1'b0;
                        cause       = CAUSE_SWITCH;
                    end
                end
                if (active_next) begin
                    elapsed = restarted ? '0 : elapsed_old;
                    if ($signed(item.temperature) > $signed(cfg.temp_limit)) begin
                        active_next = 1'b0;
                        heater_next = 1'b0;
                        cause       = CAUSE_OVERTEMP;
                        ended       = 1'b1;
                    end else if (item.humidity > cfg.humidity_limit) begin
                        active_next = 1'b0;
                        heater_next = 1'b0;
                        cause       = CAUSE_OVERHUM;
                        ended       = 1'b1;
                    end else if (!remote_reg) begin
                        dur_cur = (level_next == LEVEL_1) ? cfg.l1_duration :
                                  (level_next == LEVEL_2) ? cfg.l2_duration :
                                  cfg.l3_duration;
                        if (level_next != '0 && elapsed >= dur_cur) begin
                            if (level_next == LEVEL_1) begin
                                level_next = LEVEL_2;
                                restarted  = 1'b1;
                            end else if (level_next == LEVEL_2) begin
                                level_next = LEVEL_3;
                                restarted  = 1'b1;
                            end else begin
                                active_next = 1'b0;
                                heater_next = 1'b0;
                                cause       = CAUSE_FINISHED;
                                ended       = 1'b1;
                            end
                        end
                    end
                    if (!ended) begin
                        target = (level_next == LEVEL_1) ? cfg.l1_target :
                                 (level_next == LEVEL_2) ? cfg.l2_target :
                                 cfg.l3_target;
                        heater_next = $signed(item.temperature) < $signed(target);
                    end
                end
            end
            default: ;
        endcase

        if (restarted) begin
            start_next = item.now_ms;
            drive_next = drive_for(level_next);
        end
    end

    // Remaining time uses the state after this item.
    assign dur_fin = (level_next == LEVEL_1) ? cfg.l1_duration :
                     (level_next == LEVEL_2) ? cfg.l2_duration : cfg.l3_duration;

    always_comb begin
        logic [TIME_W-1:0] el_fin;
        el_fin = restarted ? '0 : elapsed_old;
        result.active         = active_next;
        result.level          = level_next;
        result.motor_drive    = active_next ? drive_next : '0;
        result.heater_on      = heater_next;
        result.shutdown_cause = cause;
        result.remote_mode    = remote_next;
        if (active_next && !remote_next && el_fin < dur_fin) begin
            result.remaining_ms = dur_fin - el_fin;
        end else begin
            result.remaining_ms = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            level_reg  <= LEVEL_1;
            start_reg  <= '0;
            remote_reg <= 1'b0;
            drive_reg  <= '0;
            heater_reg <= 1'b0;
        end else if (step) begin
            active_reg <= active_next;
            level_reg  <= level_next;
            start_reg  <= start_next;
            remote_reg <= remote_next;
            drive_reg  <= drive_next;
            heater_reg <= heater_next;
        end
    end

endmodule

`default_nettype wire

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlsth_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 250;
    localparam int LAST_PHASE  = 8;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [31:0] now_ms, [32] switch_closed, [44:33] temperature, [54:45] humidity,
    // [62:55] cmd_byte, [63] link_up
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // [1:0] func
    logic [FUNC_W-1:0]     s_tuser = '0;

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] active, [2:1] level, [10:3] motor_drive, [11] heater_on,
    // [14:12] shutdown_cause, [15] remote_mode, [47:16] remaining_ms
    logic [OUT_DATA_W-1:0] m_tdata;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    timed_level_sequencer_with_thermostat_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the session controller.
    cfg_t        shadow_regs;
    logic        sess_active;
    logic [1:0]  sess_level;
    logic [31:0] level_t0;
    logic        remote_on;
    logic [7:0]  drive_duty;
    logic        heater_relay;

    item_t       pending_items[$];
    result_t     pending_results[$];
    item_t       offered;
    logic        item_taken = 1'b0;
    logic        calm = 1'b0;
    logic [31:0] stamp_ms = '0;
    int          step_max = 100;
    int          items_total = 0;
    int          results_done = 0;
    int          mismatches = 0;
    int          src_gap = 0;
    int          hold_left = 0;
    int          stall_asks = 0;
    int          stall_grants = 0;
    int          idle_cycles = 0;
    int          settings_used = 1;
    int          level_advances = 0;
    int          cause_tally[6];

    function automatic void reset_shadow();
        shadow_regs.temp_limit     = TEMP_LIMIT_RST;
        shadow_regs.humidity_limit = HUM_LIMIT_RST;
        shadow_regs.l1_duration    = L1_DUR_RST;
        shadow_regs.l2_duration    = L2_DUR_RST;
        shadow_regs.l3_duration    = L3_DUR_RST;
        shadow_regs.l1_target      = L1_TARGET_RST;
        shadow_regs.l2_target      = L2_TARGET_RST;
        shadow_regs.l3_target      = L3_TARGET_RST;
        sess_active  = 1'b0;
        sess_level   = LEVEL_1;
        level_t0     = '0;
        remote_on    = 1'b0;
        drive_duty   = '0;
        heater_relay = 1'b0;
    endfunction

    function automatic void apply_reg(input cfg_idx_t idx, input logic [31:0] val);
        case (idx)
            REG_TEMP_LIMIT: shadow_regs.temp_limit     = val[11:0];
            REG_HUM_LIMIT:  shadow_regs.humidity_limit = val[9:0];
            REG_L1_DUR:     shadow_regs.l1_duration    = val;
            REG_L2_DUR:     shadow_regs.l2_duration    = val;
            REG_L3_DUR:     shadow_regs.l3_duration    = val;
            REG_L1_TARGET:  shadow_regs.l1_target      = val[11:0];
            REG_L2_TARGET:  shadow_regs.l2_target      = val[11:0];
            REG_L3_TARGET:  shadow_regs.l3_target      = val[11:0];
            default: ;
        endcase
    endfunction

    function automatic void enter_level(input logic [1:0] lvl, input logic [31:0] now);
        sess_level = lvl;
        drive_duty = (lvl == LEVEL_1) ? 8'd127 : (lvl == LEVEL_2) ? 8'd191 : 8'd255;
        level_t0   = now;
    endfunction

    function automatic cause_t halt(input cause_t why);
        sess_active  = 1'b0;
        heater_relay = 1'b0;
        return why;
    endfunction

    // An unreachable level zero shares the level three slot.
    function automatic logic [31:0] duration_of(input logic [1:0] lvl);
        return (lvl == LEVEL_1) ? shadow_regs.l1_duration :
               (lvl == LEVEL_2) ? shadow_regs.l2_duration : shadow_regs.l3_duration;
    endfunction

    function automatic result_t step_session(input item_t it);
        result_t            r;
        cause_t             why;
        logic [31:0]        elapsed;
        logic [31:0]        dur;
        logic signed [11:0] target;
        r   = '0;
        why = CAUSE_NONE;
        case (it.func)
            FUNC_LINK: remote_on = it.link_up;
            FUNC_CMD: begin
                if (it.cmd_byte == CMD_ON) begin
                    if (!sess_active) begin
                        sess_active = 1'b1;
                        enter_level(LEVEL_1, it.now_ms);
                    end
                end else if (it.cmd_byte == CMD_OFF) begin
                    if (sess_active) why = halt(CAUSE_REMOTE);
                end else if (it.cmd_byte == CMD_L1) begin
                    enter_level(LEVEL_1, it.now_ms);
                end else if (it.cmd_byte == CMD_L2) begin
                    enter_level(LEVEL_2, it.now_ms);
                end else if (it.cmd_byte == CMD_L3) begin
                    enter_level(LEVEL_3, it.now_ms);
                end
            end
            FUNC_SAMPLE: begin
                if (!remote_on) begin
                    if (it.switch_closed) begin
                        if (!sess_active) begin
                            sess_active = 1'b1;
                            enter_level(LEVEL_1, it.now_ms);
                        end
                    end else if (sess_active) begin
                        why = halt(CAUSE_SWITCH);
                    end
                end
                if (sess_active) begin
                    if (it.temperature > shadow_regs.temp_limit) begin
                        why = halt(CAUSE_OVERTEMP);
                    end else if (it.humidity > shadow_regs.humidity_limit) begin
                        why = halt(CAUSE_OVERHUM);
                    end else if (!remote_on && sess_level != 2'd0) begin
                        elapsed = it.now_ms - level_t0;
                        if (elapsed >= duration_of(sess_level)) begin
                            level_advances++;
                            if (sess_level == LEVEL_1) enter_level(LEVEL_2, it.now_ms);
                            else if (sess_level == LEVEL_2) enter_level(LEVEL_3, it.now_ms);
                            else why = halt(CAUSE_FINISHED);
                        end
                    end
                    // Any shutdown above has already cleared the session.
                    if (sess_active) begin
                        target = (sess_level == LEVEL_1) ? shadow_regs.l1_target :
                                 (sess_level == LEVEL_2) ? shadow_regs.l2_target :
                                                           shadow_regs.l3_target;
                        heater_relay = it.temperature < target;
                    end
                end
            end
            default: ;
        endcase

        if (sess_active && !remote_on) begin
            elapsed = it.now_ms - level_t0;
            dur     = duration_of(sess_level);
            r.remaining_ms = (elapsed >= dur) ? 32'd0 : dur - elapsed;
        end
        r.active         = sess_active;
        r.level          = sess_level;
        r.motor_drive    = sess_active ? drive_duty : 8'd0;
        r.heater_on      = heater_relay;
        r.shutdown_cause = why;
        r.remote_mode    = remote_on;
        cause_tally[why]++;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d, got %0d", results_done, name, want, got);
        end
    endtask

    // Sampling side: requests, register writes and results at the rising edge.
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            reset_shadow();
            item_taken <= 1'b0;
        end else begin
            item_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) apply_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) pending_results.push_back(step_session(offered));
            if (m_tvalid && m_tready) begin
                got.active         = m_tdata[0];
                got.level          = m_tdata[2:1];
                got.motor_drive    = m_tdata[10:3];
                got.heater_on      = m_tdata[11];
                got.shutdown_cause = cause_t'(m_tdata[14:12]);
                got.remote_mode    = m_tdata[15];
                got.remaining_ms   = m_tdata[47:16];
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no request outstanding: %h", m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    check_field("active", want.active, got.active);
                    check_field("level", want.level, got.level);
                    check_field("motor_drive", want.motor_drive, got.motor_drive);
                    check_field("heater_on", want.heater_on, got.heater_on);
                    check_field("shutdown_cause", want.shutdown_cause, got.shutdown_cause);
                    check_field("remote_mode", want.remote_mode, got.remote_mode);
                    check_field("remaining_ms", want.remaining_ms, got.remaining_ms);
                    results_done++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d of %0d results in",
                     idle_cycles, results_done, items_total);
            $display("[timed_level_sequencer_with_thermostat_unit] ERROR");
            $finish;
        end
    end

    // Request driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || item_taken) begin
            if (src_gap > 0) begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                offered  = pending_items.pop_front();
                s_tdata  <= {offered.link_up, offered.cmd_byte, offered.humidity,
                             offered.temperature, offered.switch_closed, offered.now_ms};
                s_tuser  <= offered.func;
                s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random stalls and, on request, one long hold-off.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_grants != stall_asks) begin
            stall_grants <= stall_grants + 1;
            hold_left    <= LONG_HOLD - 1;
            m_tready     <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            hold_left <= $urandom_range(0, 14);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic add_item(input func_t f, input logic [31:0] now, input logic sw,
                            input int temp, input int hum, input logic [7:0] cmd,
                            input logic link);
        item_t it;
        it.func          = f;
        it.now_ms        = now;
        it.switch_closed = sw;
        it.temperature   = temp[TEMP_W-1:0];
        it.humidity      = hum[HUM_W-1:0];
        it.cmd_byte      = cmd;
        it.link_up       = link;
        pending_items.push_back(it);
        items_total++;
    endtask

    // Mostly sessions on a running clock with temperatures around the targets.
    task automatic add_random_item();
        func_t       f;
        logic        sw;
        logic        link;
        logic [7:0]  cmd;
        int          temp;
        int          hum;
        int          base;
        int          pick;
        sw   = 1'($urandom_range(0, 1));
        link = 1'($urandom_range(0, 1));
        cmd  = 8'($urandom_range(0, 255));
        temp = int'($urandom_range(0, 1650)) - 400;
        hum  = $urandom_range(0, 1000);
        if ($urandom_range(0, 99) == 0) stamp_ms -= $urandom_range(0, 100000);
        else stamp_ms += $urandom_range(0, step_max);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            f  = FUNC_SAMPLE;
            sw = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 19) != 0) begin
                case ($urandom_range(0, 2))
                    0: base = int'(shadow_regs.l1_target);
                    1: base = int'(shadow_regs.l2_target);
                    default: base = int'(shadow_regs.l3_target);
                endcase
                temp = base + int'($urandom_range(0, 80)) - 40;
                if (temp > 1250) temp = 1250;
                if (temp < -400) temp = -400;
            end
            if ($urandom_range(0, 29) != 0) hum = $urandom_range(0, shadow_regs.humidity_limit);
        end else if (pick < 90) begin
            f = FUNC_CMD;
            case ($urandom_range(0, 6))
                0: cmd = CMD_ON;
                1: cmd = CMD_OFF;
                2: cmd = CMD_L1;
                3: cmd = CMD_L2;
                4: cmd = CMD_L3;
                default: ;
            endcase
        end else if (pick < 98) begin
            f    = FUNC_LINK;
            link = ($urandom_range(0, 2) == 0);
        end else begin
            f = FUNC_NONE;
        end
        add_item(f, stamp_ms, sw, temp, hum, cmd, link);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_done != items_total) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    initial begin
        int          n;
        int          lim;
        int          hum;
        int          tgt[3];
        logic [31:0] dur[3];

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests on the reset register values.
        add_item(FUNC_LINK,   0,    0, 0,    0,   8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 10,   0, 200,  300, 8'h00, 1'b0); // switch open, idle
        add_item(FUNC_CMD,    20,   0, 0,    0,   CMD_OFF, 1'b0); // stop while idle
        add_item(FUNC_CMD,    30,   0, 0,    0,   CMD_L2, 1'b0); // level set, no start
        add_item(FUNC_CMD,    40,   0, 0,    0,   CMD_ON, 1'b0);
        add_item(FUNC_SAMPLE, 50,   1, 340,  750, 8'h00, 1'b0); // at target and humidity limit
        add_item(FUNC_SAMPLE, 60,   1, 339,  0,   8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 70,   1, 420,  100, 8'h00, 1'b0); // at temperature limit
        add_item(FUNC_SAMPLE, 80,   1, 421,  100, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 1000, 1, -400, 100, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 1010, 1, 300,  751, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 2000, 1, 300,  400, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 661999,  1, 300, 400, 8'h00, 1'b0); // one short of level two
        add_item(FUNC_SAMPLE, 662000,  1, 350, 400, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 1322000, 1, 370, 400, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 1802000, 1, 300, 400, 8'h00, 1'b0); // cycle finished
        add_item(FUNC_CMD,    1802010, 0, 0,   0,   8'h00, 1'b0);
        add_item(FUNC_CMD,    1802020, 0, 0,   0,   8'hFF, 1'b0);
        add_item(FUNC_CMD,    32'hFFFF_FF00, 0, 0, 0, CMD_ON, 1'b0);
        add_item(FUNC_CMD,    32'hFFFF_FFFF, 0, 0, 0, CMD_L3, 1'b0);
        add_item(FUNC_LINK,   5,    0, 0,    0,   8'h00, 1'b1);
        add_item(FUNC_SAMPLE, 0,    0, 100,  200, 8'h00, 1'b0); // switch ignored in remote
        add_item(FUNC_CMD,    20,   0, 0,    0,   CMD_OFF, 1'b0);
        add_item(FUNC_NONE,   32'hFFFF_FFFF, 1, -1, 1023, 8'hFF, 1'b1);
        add_item(FUNC_LINK,   30,   0, 0,    0,   8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 40,   1, 1250, 1000, 8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 50,   1, 0,    0,   8'h00, 1'b0);
        add_item(FUNC_SAMPLE, 60,   0, 0,    0,   8'h00, 1'b0);
        wait_drained();

        for (int ph = 1; ph <= LAST_PHASE; ph++) begin
            if (ph == 1) begin
                lim = 1250; hum = 1000;
                tgt = '{1250, 1250, 1250};
                dur = '{32'd1, 32'd1, 32'd1};
                n = 150; step_max = 3;
            end else if (ph == 2) begin
                lim = -400; hum = 0;
                tgt = '{-400, -400, -400};
                dur = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                n = 100; step_max = 1000;
            end else begin
                foreach (tgt[i]) tgt[i] = int'($urandom_range(0, 700)) - 100;
                lim = (tgt[0] > tgt[1]) ? tgt[0] : tgt[1];
                lim = ((lim > tgt[2]) ? lim : tgt[2]) + int'($urandom_range(0, 150));
                hum = $urandom_range(400, 1000);
                foreach (dur[i]) dur[i] = $urandom_range(50, 1500);
                n = 290; step_max = 400;
                if (ph == 5) stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            end
            write_reg(REG_TEMP_LIMIT, lim);
            write_reg(REG_HUM_LIMIT, hum);
            write_reg(REG_L1_DUR, dur[0]);
            write_reg(REG_L2_DUR, dur[1]);
            write_reg(REG_L3_DUR, dur[2]);
            write_reg(REG_L1_TARGET, tgt[0]);
            write_reg(REG_L2_TARGET, tgt[1]);
            write_reg(REG_L3_TARGET, tgt[2]);
            settings_used++;
            if (ph == LAST_PHASE) calm = 1'b1;

            // Halfway through each setting the sender waits for all results.
            for (int i = 0; i < n / 2; i++) add_random_item();
            if (ph == 4) stall_asks++;
            wait_drained();
            for (int i = n / 2; i < n; i++) add_random_item();
            wait_drained();
        end

        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Checked %0d results over %0d register settings, %0d timed level changes.",
                 results_done, settings_used, level_advances);
        $display("Shutdowns: switch %0d, remote %0d, over-temp %0d, over-humidity %0d, %s %0d.",
                 cause_tally[CAUSE_SWITCH], cause_tally[CAUSE_REMOTE],
                 cause_tally[CAUSE_OVERTEMP], cause_tally[CAUSE_OVERHUM],
                 "finished", cause_tally[CAUSE_FINISHED]);
        if (mismatches == 0)
            $display("[timed_level_sequencer_with_thermostat_unit] OK");
        else
            $display("[timed_level_sequencer_with_thermostat_unit] ERROR");
        $finish;
    end

endmodule
